// ===== sv/e2q_pkg.sv =====
`default_nettype none
package e2q_pkg;
	localparam int FB = 40;
	localparam int AW = 46;
	localparam logic signed [AW-1:0] PI_Q40 = 46'sh3243F6A8886;
	localparam logic signed [AW-1:0] HALF_PI_Q40 = 46'sh1921FB54443;
	localparam logic signed [AW-1:0] KINF_Q40 = 46'sh9B74EDA843;
	localparam logic signed [AW-1:0] KTWO_Q40 = KINF_Q40 * 2 / 3;

	typedef logic signed [AW-1:0] acc_t;
	typedef logic signed [32:0] unit_t;

	// Unsigned restoring division, used only while building constants.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		int b;
		q = 64'd0;
		r = 65'd0;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Arctangent of 2^-i in Q.40: pi/4 for i = 0, else from a truncated series in Q.60.
	function automatic acc_t atan_pow2(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		int k;
		sum = 64'd0;
		if (i == 0) begin
			return 46'shC90FDAA221;
		end
		for (k = 0; k < 31; k++) begin
			if (i * (2 * k + 1) <= 60) begin
				term = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
				if ((k & 1) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		sum = (sum + (64'd1 << 19)) >> 20;
		return sum[AW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== sv/euler_to_quaternion_unit.sv =====
`default_nettype none
// Converts Z-Y-X Euler angles (Q3.28 radians) into a quaternion (Q1.30).
// Fully pipelined: one transfer per cycle in and out. A fold stage feeds
// the CORDIC stages, one per iteration, followed by the rounding, pair
// product, pair rounding, triple product and output rounding stages. The
// whole pipeline holds while the output is stalled.
module euler_to_quaternion_unit #(
	parameter int TRIG_ITERATIONS = 24
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire signed [31:0]  roll_angle,
	input  wire signed [31:0]  pitch_angle,
	input  wire signed [31:0]  yaw_angle,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z
);
	import e2q_pkg::*;

	localparam int N = TRIG_ITERATIONS;
	localparam int GS = (2 * N < 63) ? 2 * N : 63;
	localparam acc_t GAIN = KINF_Q40 + (KTWO_Q40 >>> GS);

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 0: fold half angles into [-pi/2, pi/2].
	acc_t x_s [3][N+1];
	acc_t y_s [3][N+1];
	acc_t z_s [3][N+1];
	logic flip_s [3][N+1];
	logic v_s [N+1];

	logic signed [31:0] ang [3];
	assign ang[0] = roll_angle;
	assign ang[1] = pitch_angle;
	assign ang[2] = yaw_angle;

	for (genvar a = 0; a < 3; a++) begin : g_ax
		acc_t h;
		assign h = {{(AW-43){ang[a][31]}}, ang[a], 11'd0};
		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[a][0] <= GAIN;
				y_s[a][0] <= '0;
				if (h > HALF_PI_Q40) begin
					z_s[a][0] <= h - PI_Q40;
					flip_s[a][0] <= 1'b1;
				end else if (h < -HALF_PI_Q40) begin
					z_s[a][0] <= h + PI_Q40;
					flip_s[a][0] <= 1'b1;
				end else begin
					z_s[a][0] <= h;
					flip_s[a][0] <= 1'b0;
				end
			end
		end
		for (genvar i = 0; i < N; i++) begin : g_it
			localparam acc_t ATN = atan_pow2(i);
			always_ff @(posedge clk) begin
				if (adv) begin
					flip_s[a][i+1] <= flip_s[a][i];
					if (z_s[a][i] >= 0) begin
						x_s[a][i+1] <= x_s[a][i] - (y_s[a][i] >>> i);
						y_s[a][i+1] <= y_s[a][i] + (x_s[a][i] >>> i);
						z_s[a][i+1] <= z_s[a][i] - ATN;
					end else begin
						x_s[a][i+1] <= x_s[a][i] + (y_s[a][i] >>> i);
						y_s[a][i+1] <= y_s[a][i] - (x_s[a][i] >>> i);
						z_s[a][i+1] <= z_s[a][i] + ATN;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int i = 0; i < N; i++) v_s[i+1] <= v_s[i];
		end
	end

	function automatic unit_t rnd31(input acc_t v, input logic f);
		acc_t t;
		acc_t r;
		t = f ? -v : v;
		r = (t + acc_t'(256)) >>> 9;
		if (r > acc_t'(64'sh80000000)) return 33'sh080000000;
		if (r < -acc_t'(64'sh80000000)) return -33'sh080000000;
		return r[32:0];
	endfunction

	// Stage A: sine and cosine rounded to Q.31.
	unit_t c_sa [3];
	unit_t s_sa [3];
	logic v_sa;
	// Stage B: pair products.
	unit_t cr_sb, sr_sb;
	logic signed [65:0] pcc_sb, pss_sb, psc_sb, pcs_sb;
	logic v_sb;
	// Stage C: pair products rounded.
	unit_t cr_sc, sr_sc, pcc_sc, pss_sc, psc_sc, pcs_sc;
	logic v_sc;
	// Stage D: triple products in Q.62.
	logic signed [65:0] t_sd [8];
	logic v_sd;

	function automatic unit_t rnd_pair(input logic signed [65:0] p);
		logic signed [65:0] r;
		r = (p + 66'sd1073741824) >>> 31;
		return r[32:0];
	endfunction

	function automatic logic signed [31:0] fin(input logic signed [65:0] a,
		input logic signed [65:0] b, input logic add);
		logic signed [67:0] s;
		logic signed [67:0] r;
		s = add ? (68'(a) + 68'(b)) : (68'(a) - 68'(b));
		r = (s + 68'sh80000000) >>> 32;
		if (r > 68'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (r < -68'sh80000000) return 32'sh80000000;
		return r[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				c_sa[a] <= rnd31(x_s[a][N], flip_s[a][N]);
				s_sa[a] <= rnd31(y_s[a][N], flip_s[a][N]);
			end
			cr_sb <= c_sa[0];
			sr_sb <= s_sa[0];
			pcc_sb <= 66'(c_sa[1]) * 66'(c_sa[2]);
			pss_sb <= 66'(s_sa[1]) * 66'(s_sa[2]);
			psc_sb <= 66'(s_sa[1]) * 66'(c_sa[2]);
			pcs_sb <= 66'(c_sa[1]) * 66'(s_sa[2]);
			cr_sc <= cr_sb;
			sr_sc <= sr_sb;
			pcc_sc <= rnd_pair(pcc_sb);
			pss_sc <= rnd_pair(pss_sb);
			psc_sc <= rnd_pair(psc_sb);
			pcs_sc <= rnd_pair(pcs_sb);
			t_sd[0] <= 66'(cr_sc) * 66'(pcc_sc);
			t_sd[1] <= 66'(sr_sc) * 66'(pss_sc);
			t_sd[2] <= 66'(sr_sc) * 66'(pcc_sc);
			t_sd[3] <= 66'(cr_sc) * 66'(pss_sc);
			t_sd[4] <= 66'(cr_sc) * 66'(psc_sc);
			t_sd[5] <= 66'(sr_sc) * 66'(pcs_sc);
			t_sd[6] <= 66'(cr_sc) * 66'(pcs_sc);
			t_sd[7] <= 66'(sr_sc) * 66'(psc_sc);
			quat_w <= fin(t_sd[0], t_sd[1], 1'b1);
			quat_x <= fin(t_sd[2], t_sd[3], 1'b0);
			quat_y <= fin(t_sd[4], t_sd[5], 1'b1);
			quat_z <= fin(t_sd[6], t_sd[7], 1'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
			v_sb <= 1'b0;
			v_sc <= 1'b0;
			v_sd <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_sa <= v_s[N];
			v_sb <= v_sa;
			v_sc <= v_sb;
			v_sd <= v_sc;
			out_valid <= v_sd;
		end
	end
endmodule
`default_nettype wire
